// ===== hw/rtl/gcp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcp_pkg: shared types, constants and elaboration-time functions
// Field widths, pipeline depth, register codes and the constant functions
// that build the log2 reference value and the exp2 root constants.
// ----------------------------------------------------------------------------
package gcp_pkg;

  localparam int FIELD_W  = 16;  // width of every pixel field port
  localparam int GAMMA_W  = 16;  // width of every exponent register
  localparam int NUM_CH   = 4;
  localparam int LOG_FRAC = 30;  // fraction bits of the log2 value
  localparam int EXP_W    = 5;   // integer part of log2, up to 23
  localparam int LOG_W    = EXP_W + LOG_FRAC;
  localparam int MAX_CB   = 24;
  // normalize + 30 squarings + subtract + multiply + split
  // + 30 root steps + scale + round
  localparam int LAT      = 1 + LOG_FRAC + 1 + 1 + 1 + LOG_FRAC + 1 + 1;

  typedef logic [NUM_CH-1:0][FIELD_W-1:0] pix_t;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_ALPHA = 2'd3
  } reg_idx_t;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = 64'd0;
    bt  = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q0.32, k = 1..LOG_FRAC
  function automatic logic [31:0] root_c(input int k);
    logic [63:0] c;
    c = floor_sqrt(64'd1 << 63);
    for (int j = 2; j <= k; j++) begin
      c = floor_sqrt(c << 32);
    end
    return c[31:0];
  endfunction

  // log2 of v >= 1 as integer part and LOG_FRAC fraction bits
  function automatic logic [LOG_W-1:0] fixed_log2(input logic [MAX_CB-1:0] v);
    logic [EXP_W-1:0] e;
    logic [63:0]      m;
    logic [LOG_FRAC-1:0] fr;
    e  = '0;
    fr = '0;
    for (int b = 0; b < MAX_CB; b++) begin
      if (v[b]) e = EXP_W'(b);
    end
    m = 64'(v) << (31 - int'(e));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m  = (m * m) >> 31;
      fr = {fr[LOG_FRAC-2:0], m[32]};
      if (m[32]) m = m >> 1;
    end
    return {e, fr};
  endfunction

endpackage

// ===== hw/rtl/gcp_lane.sv =====
// ----------------------------------------------------------------------------
// gcp_lane: one channel of the power-law pipeline
// Normalize, log2 by repeated squaring, scale by the exponent, exp2 by a
// product of root constants, then rescale, round and saturate.
// ----------------------------------------------------------------------------
module gcp_lane #(
  parameter int CHANNEL_BITS       = 16,
  parameter int EXPONENT_FRAC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [gcp_pkg::FIELD_W-1:0]  x_in,
  input  logic [gcp_pkg::GAMMA_W-1:0]  gamma,
  output logic [gcp_pkg::FIELD_W-1:0]  res
);

  localparam int CB   = CHANNEL_BITS;
  localparam int EB   = EXPONENT_FRAC_BITS;
  localparam int LF   = gcp_pkg::LOG_FRAC;
  localparam int EW   = gcp_pkg::EXP_W;
  localparam int LW   = gcp_pkg::LOG_W;
  localparam int LAT  = gcp_pkg::LAT;
  localparam int PW   = LW + gcp_pkg::GAMMA_W;
  localparam int QW   = PW - EB;
  localparam int IPW  = QW - LF;
  localparam int SW   = CB + 33;
  localparam int RW   = CB + 34;
  localparam logic [CB-1:0] FULL     = {CB{1'b1}};
  localparam logic [LW-1:0] LOG_FULL =
    gcp_pkg::fixed_log2(gcp_pkg::MAX_CB'(FULL));

  // stage 0: special cases and normalization
  logic [CB-1:0]  x;
  logic [EW-1:0]  e_c;
  logic           frc_c;
  logic           one_c;

  assign x     = CB'(x_in);
  assign frc_c = (gamma == '0) || (x == '0) || (x == FULL);
  assign one_c = (gamma == '0) || (x == FULL);

  always_comb begin
    e_c = '0;
    for (int b = 0; b < CB; b++) begin
      if (x[b]) e_c = EW'(b);
    end
  end

  logic [31:0]    m_r  [0:LF];
  logic [LF-1:0]  fr_r [0:LF];
  logic [EW-1:0]  e_r  [0:LF];
  logic [1:0]     fl_r [0:LAT-2];  // {force, force value is full scale}

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= 32'(x) << (5'd31 - e_c);
      fr_r[0] <= '0;
      e_r[0]  <= e_c;
      fl_r[0] <= {frc_c, one_c};
    end
  end

  for (genvar s = 1; s <= LAT - 2; s++) begin : g_flag
    always_ff @(posedge clk) begin
      if (en) fl_r[s] <= fl_r[s-1];
    end
  end

  // log2 fraction: one squaring per stage
  for (genvar j = 1; j <= LF; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_r[j-1]) * 64'(m_r[j-1]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j]  <= t[32] ? t[32:1] : t[31:0];
        fr_r[j] <= {fr_r[j-1][LF-2:0], t[32]};
        e_r[j]  <= e_r[j-1];
      end
    end
  end

  // distance below full scale, then scale by the exponent
  logic [LW-1:0] n_r;
  logic [PW-1:0] pm;
  logic [QW-1:0] p_r;

  assign pm = PW'(n_r) * PW'(gamma) + (PW'(1) << (EB - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= LOG_FULL - {e_r[LF], fr_r[LF]};
      p_r <= pm[PW-1:EB];
    end
  end

  // exp2: split integer and fraction, then one root constant per stage
  logic [31:0]    r_r   [0:LF];
  logic           one_r [0:LF];
  logic [LF-1:0]  f_r   [0:LF];
  logic [EW-1:0]  ip_r  [0:LF];
  logic           kill_r[0:LF];
  logic [IPW-1:0] ip_w;

  assign ip_w = p_r[QW-1:LF];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= '0;
      one_r[0]  <= 1'b1;
      f_r[0]    <= p_r[LF-1:0];
      ip_r[0]   <= EW'(ip_w);
      kill_r[0] <= ip_w > IPW'(CB);
    end
  end

  for (genvar k = 1; k <= LF; k++) begin : g_exp
    localparam logic [31:0] C = gcp_pkg::root_c(k);
    logic [63:0] rp;
    logic        hit;
    assign rp  = 64'(r_r[k-1]) * 64'(C);
    assign hit = f_r[k-1][LF-k];
    always_ff @(posedge clk) begin
      if (en) begin
        if (hit) begin
          r_r[k] <= one_r[k-1] ? C : rp[63:32];
        end else begin
          r_r[k] <= r_r[k-1];
        end
        one_r[k]  <= one_r[k-1] & ~hit;
        f_r[k]    <= f_r[k-1];
        ip_r[k]   <= ip_r[k-1];
        kill_r[k] <= kill_r[k-1];
      end
    end
  end

  // rescale to full scale, round to nearest, saturate
  logic [SW-1:0]  sc_r;
  logic [EW-1:0]  ip2_r;
  logic           kill2_r;
  logic [RW-1:0]  sum;
  logic [RW-1:0]  sh;
  logic [CB-1:0]  val;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r    <= SW'(FULL) * SW'({one_r[LF], r_r[LF]});
      ip2_r   <= ip_r[LF];
      kill2_r <= kill_r[LF];
    end
  end

  assign sum = RW'(sc_r) + (RW'(1) << (6'd31 + 6'(ip2_r)));
  assign sh  = sum >> (6'd32 + 6'(ip2_r));

  always_comb begin
    priority if (fl_r[LAT-2][1]) begin
      val = fl_r[LAT-2][0] ? FULL : '0;
    end else if (kill2_r) begin
      val = '0;
    end else if (sh > RW'(FULL)) begin
      val = FULL;
    end else begin
      val = sh[CB-1:0];
    end
  end

  logic [gcp_pkg::FIELD_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (en) res_r <= gcp_pkg::FIELD_W'(val);
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/gcp_merge.sv =====
// ----------------------------------------------------------------------------
// gcp_merge: joins the lane results into one pixel and buffers it
// Two-entry output queue; full stalls the lanes.
// ----------------------------------------------------------------------------
module gcp_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gcp_pkg::pix_t pix_in,
  input  logic          out_ready,
  output logic          out_valid,
  output gcp_pkg::pix_t pix_out,
  output logic          full
);

  gcp_pkg::pix_t mem [0:1];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign pop       = out_valid && out_ready;
  assign pix_out   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= pix_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/per_channel_gamma_correction.sv =====
// ----------------------------------------------------------------------------
// per_channel_gamma_correction: RGBA power-law correction, out = in^gamma
// Four identical lanes, one per channel, feed a two-entry output queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one pixel per transfer (in_valid/in_ready), Q0.16 channels.
//   out_*  : one corrected pixel per transfer (out_valid/out_ready).
//   cfg_*  : exponent writes, index 0..3 = red, green, blue, alpha, Q4.12.
//            cfg_ready is always high. Write only while no pixel is in flight.
// Depth: each lane holds 30 squaring stages for log2 and 30 root stages
//   for exp2, between an input transfer and the output queue.
// Throughput: one pixel per clock while the receiver keeps taking results.
// Stall: the output queue holds two pixels; once both are filled the whole
//   lane pipeline freezes and in_ready drops until a transfer frees a slot.
//   in_ready comes straight from the queue count, never from out_ready.
// Reset: all pixels in flight are dropped, exponents return to 1.0.
// ----------------------------------------------------------------------------
module per_channel_gamma_correction #(
  parameter int CHANNEL_BITS       = 16,
  parameter int EXPONENT_FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gcp_pkg::FIELD_W-1:0] in_red,
  input  logic [gcp_pkg::FIELD_W-1:0] in_green,
  input  logic [gcp_pkg::FIELD_W-1:0] in_blue,
  input  logic [gcp_pkg::FIELD_W-1:0] in_alpha,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gcp_pkg::FIELD_W-1:0] out_red,
  output logic [gcp_pkg::FIELD_W-1:0] out_green,
  output logic [gcp_pkg::FIELD_W-1:0] out_blue,
  output logic [gcp_pkg::FIELD_W-1:0] out_alpha,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  gcp_pkg::reg_idx_t           cfg_index,
  input  logic [gcp_pkg::GAMMA_W-1:0] cfg_data
);

  localparam int LAT = gcp_pkg::LAT;
  localparam logic [gcp_pkg::GAMMA_W-1:0] GAMMA_RST =
    gcp_pkg::GAMMA_W'(64'd1 << EXPONENT_FRAC_BITS);

  // exponent registers, one per channel
  logic [gcp_pkg::GAMMA_W-1:0] gamma_r [0:gcp_pkg::NUM_CH-1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < gcp_pkg::NUM_CH; c++) gamma_r[c] <= GAMMA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gcp_pkg::REG_RED:   gamma_r[0] <= cfg_data;
        gcp_pkg::REG_GREEN: gamma_r[1] <= cfg_data;
        gcp_pkg::REG_BLUE:  gamma_r[2] <= cfg_data;
        gcp_pkg::REG_ALPHA: gamma_r[3] <= cfg_data;
        default:            ;
      endcase
    end
  end

  // advance the whole pipeline unless the output queue is full
  logic          en;
  logic          full;
  logic          push;
  logic          vld_r [0:LAT-1];
  gcp_pkg::pix_t in_pix;
  gcp_pkg::pix_t lane_pix;
  gcp_pkg::pix_t out_pix;

  assign en       = ~full;
  assign in_ready = en;
  assign push     = en && vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LAT; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < LAT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  assign in_pix[0] = in_red;
  assign in_pix[1] = in_green;
  assign in_pix[2] = in_blue;
  assign in_pix[3] = in_alpha;

  for (genvar c = 0; c < gcp_pkg::NUM_CH; c++) begin : g_lane
    gcp_lane #(
      .CHANNEL_BITS       (CHANNEL_BITS),
      .EXPONENT_FRAC_BITS (EXPONENT_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .x_in  (in_pix[c]),
      .gamma (gamma_r[c]),
      .res   (lane_pix[c])
    );
  end

  gcp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pix_in    (lane_pix),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pix_out   (out_pix),
    .full      (full)
  );

  assign out_red   = out_pix[0];
  assign out_green = out_pix[1];
  assign out_blue  = out_pix[2];
  assign out_alpha = out_pix[3];

endmodule

// ===== hw/rtl/gcp_chk.sv =====
// ----------------------------------------------------------------------------
// gcp_chk: port-level checks for per_channel_gamma_correction
// Watches the handshakes and the queue behavior seen from outside.
// ----------------------------------------------------------------------------
module gcp_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gcp_pkg::FIELD_W-1:0] out_red,
  input logic [gcp_pkg::FIELD_W-1:0] out_alpha
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_alpha))
    else $error("result changed while stalled");

  // input only blocks when the queue holds results
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output queue");

  // reset drops everything in flight
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty after reset");

endmodule

bind per_channel_gamma_correction gcp_chk u_gcp_chk (.*);
